// File: design/satq_pkg.sv
// Package for the sorted alarm timer queue: types, constants and control codes.
package satq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 40;
  localparam int PER_W       = 32;
  localparam int ID_W        = 8;
  localparam int DAY_SECONDS = 86400;

  // Opcodes
  localparam logic [1:0] OP_CHECK  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OLD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Table operations issued to the datapath
  localparam logic [1:0] DP_NONE     = 2'd0;
  localparam logic [1:0] DP_REM_ID   = 2'd1;
  localparam logic [1:0] DP_REM_HEAD = 2'd2;
  localparam logic [1:0] DP_PLACE    = 2'd3;

  // Result kinds loaded into the output register
  localparam logic [2:0] RES_OK      = 3'd0;
  localparam logic [2:0] RES_OLD     = 3'd1;
  localparam logic [2:0] RES_FULL    = 3'd2;
  localparam logic [2:0] RES_FIRED   = 3'd3;
  localparam logic [2:0] RES_PENDING = 3'd4;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ID_W-1:0]   alarm_id;
    logic [TIME_W-1:0] target_time;
    logic [PER_W-1:0]  repeat_period;
    logic              from_date;
    logic [TIME_W-1:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              fired;
    logic [ID_W-1:0]   fired_id;
    logic              head_pending;
    logic [TIME_W-1:0] wait_seconds;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [PER_W-1:0]  period;
  } slot_t;

  typedef struct packed {
    logic       capture;
    logic       adjust;
    logic [1:0] tbl_op;
    logic       load_out;
    logic [2:0] res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       empty;
    logic       full;
    logic       has_id;
    logic       head_lt;
    logic       reject;
    logic       head_rep;
  } dp_stat_t;

endpackage

// File: design/sorted_alarm_timer_queue_top.sv
// Top level of the sorted alarm timer queue.
//
// Input channel (in_valid / in_stall / in_item): one operation per item:
// check, insert or delete, with the present time. Result channel
// (out_valid / out_stall / out_item): exactly one result item per input item.
// The table holds up to 16 alarms sorted by deadline in slot registers;
// every insert, removal and reinsertion moves all slots in parallel.
// The controller steps through adjust, decide, place and write result; the
// place step runs only when a table entry is placed (insert, or a fired alarm
// with a repeat period). The block works on one item at a time; in_stall is
// low only while the controller is idle, so a new item is taken only after the
// last one's result has been written to the output register.
// The result register parts the two channels: the next item is accepted while
// a result waits, and its own result waits in the controller until the
// output register is free. A stalled result holds its value.
// Reset (rst_n low, synchronous) empties the table and drops any result.
module sorted_alarm_timer_queue_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  satq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output satq_pkg::out_item_t out_item
);

  satq_pkg::dp_cmd_t  cmd;
  satq_pkg::dp_stat_t stat;

  satq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  satq_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

// File: design/satq_datapath.sv
// Datapath: operand registers, sorted slot table, arithmetic and output register.
module satq_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  satq_pkg::in_item_t  in_item,
  input  satq_pkg::dp_cmd_t   cmd,
  output satq_pkg::dp_stat_t  stat,
  output satq_pkg::out_item_t out_item
);

  localparam int D = satq_pkg::QUEUE_DEPTH;
  localparam int TW = satq_pkg::TIME_W;

  // Operand registers
  logic [1:0]                 op_code_r;
  logic [satq_pkg::ID_W-1:0]  op_id_r;
  logic [TW-1:0]              op_tgt_r, op_tgt_nxt;
  logic [satq_pkg::PER_W-1:0] op_per_r;
  logic                       op_fd_r;
  logic [TW-1:0]              op_now_r;
  logic                       adj_r;
  logic                       head_lt_r;
  logic [TW-1:0]              wait_r;
  logic [satq_pkg::ID_W-1:0]  fid_r;

  // Slot table, valid entries form a prefix of length cnt_r
  satq_pkg::slot_t            slot_r [D];
  satq_pkg::slot_t            slot_nxt [D];
  logic [satq_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  satq_pkg::out_item_t        out_r, out_nxt;

  logic [D-1:0]  vld, match, gone, le;
  logic          has_id;
  logic [TW:0]   day_sum, rep_sum;
  logic [TW-1:0] day_sat, rep_sat;
  logic          past;
  satq_pkg::slot_t new_slot;

  // Per-slot compares
  always_comb begin
    for (int i = 0; i < D; i++) begin
      vld[i]   = satq_pkg::CNT_W'(i) < cnt_r;
      match[i] = vld[i] && (slot_r[i].id == op_id_r);
      le[i]    = vld[i] && (slot_r[i].deadline <= op_tgt_r);
    end
    gone[0] = match[0];
    for (int i = 1; i < D; i++) begin
      gone[i] = gone[i-1] | match[i];
    end
  end

  assign has_id = |match;

  // Saturating adds: next-day adjustment and repeat reinsertion
  assign day_sum = {1'b0, op_tgt_r} + (TW + 1)'(satq_pkg::DAY_SECONDS);
  assign day_sat = day_sum[TW] ? {TW{1'b1}} : day_sum[TW-1:0];
  assign rep_sum = {1'b0, slot_r[0].deadline} + (TW + 1)'(slot_r[0].period);
  assign rep_sat = rep_sum[TW] ? {TW{1'b1}} : rep_sum[TW-1:0];
  assign past    = op_fd_r && (op_tgt_r < op_now_r);

  assign new_slot = '{id: op_id_r, deadline: op_tgt_r, period: op_per_r};

  // Table update
  always_comb begin
    cnt_nxt    = cnt_r;
    op_tgt_nxt = op_tgt_r;
    for (int i = 0; i < D; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    if (cmd.capture) begin
      op_tgt_nxt = in_item.target_time;
    end
    if (cmd.adjust && past) begin
      op_tgt_nxt = day_sat;
    end
    case (cmd.tbl_op)
      satq_pkg::DP_REM_ID: begin
        if (has_id) begin
          for (int i = 0; i < D - 1; i++) begin
            if (gone[i]) slot_nxt[i] = slot_r[i+1];
          end
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      satq_pkg::DP_REM_HEAD: begin
        for (int i = 0; i < D - 1; i++) begin
          slot_nxt[i] = slot_r[i+1];
        end
        cnt_nxt    = cnt_r - 1'b1;
        op_tgt_nxt = rep_sat;
      end
      satq_pkg::DP_PLACE: begin
        // New entry goes after every entry with deadline <= its own
        if (!le[0]) slot_nxt[0] = new_slot;
        for (int i = 1; i < D; i++) begin
          if (!le[i]) slot_nxt[i] = le[i-1] ? new_slot : slot_r[i-1];
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < D; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
    op_tgt_r <= op_tgt_nxt;
    out_r    <= out_nxt;
    if (cmd.capture) begin
      op_code_r <= in_item.opcode;
      op_id_r   <= in_item.alarm_id;
      op_per_r  <= in_item.repeat_period;
      op_fd_r   <= in_item.from_date;
      op_now_r  <= in_item.current_time;
    end
    if (cmd.adjust) begin
      adj_r     <= past;
      head_lt_r <= op_now_r < slot_r[0].deadline;
      wait_r    <= slot_r[0].deadline - op_now_r;
    end
    if (cmd.tbl_op == satq_pkg::DP_REM_HEAD) begin
      fid_r    <= slot_r[0].id;
      op_id_r  <= slot_r[0].id;
      op_per_r <= slot_r[0].period;
    end
  end

  // Result formatting
  always_comb begin
    out_nxt = out_r;
    if (cmd.load_out) begin
      out_nxt = '0;
      case (cmd.res_kind)
        satq_pkg::RES_OLD:  out_nxt.status = satq_pkg::ST_OLD;
        satq_pkg::RES_FULL: out_nxt.status = satq_pkg::ST_FULL;
        satq_pkg::RES_FIRED: begin
          out_nxt.fired    = 1'b1;
          out_nxt.fired_id = fid_r;
        end
        satq_pkg::RES_PENDING: begin
          out_nxt.head_pending = 1'b1;
          out_nxt.wait_seconds = wait_r;
        end
        default: out_nxt.status = satq_pkg::ST_OK;
      endcase
    end
  end

  assign out_item = out_r;

  assign stat.opcode   = op_code_r;
  assign stat.empty    = (cnt_r == '0);
  assign stat.full     = (cnt_r == satq_pkg::CNT_W'(D));
  assign stat.has_id   = has_id;
  assign stat.head_lt  = head_lt_r;
  assign stat.reject   = adj_r && (op_tgt_r < op_now_r);
  assign stat.head_rep = (slot_r[0].period != '0);

endmodule

// File: design/satq_ctrl.sv
// Controller: sequences one operation at a time and drives the handshakes.
module satq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  satq_pkg::dp_stat_t stat,
  output satq_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADJ   = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ADJ;
        end
      end
      S_ADJ: begin
        cmd.adjust = 1'b1;
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_OUT;
        res_nxt   = satq_pkg::RES_OK;
        unique case (stat.opcode)
          satq_pkg::OP_CHECK: begin
            if (stat.empty) begin
              res_nxt = satq_pkg::RES_OK;
            end else if (stat.head_lt) begin
              res_nxt = satq_pkg::RES_PENDING;
            end else begin
              cmd.tbl_op = satq_pkg::DP_REM_HEAD;
              res_nxt    = satq_pkg::RES_FIRED;
              if (stat.head_rep) state_nxt = S_PLACE;
            end
          end
          satq_pkg::OP_INSERT: begin
            if (stat.reject) begin
              res_nxt = satq_pkg::RES_OLD;
            end else if (!stat.has_id && stat.full) begin
              res_nxt = satq_pkg::RES_FULL;
            end else begin
              if (stat.has_id) cmd.tbl_op = satq_pkg::DP_REM_ID;
              state_nxt = S_PLACE;
            end
          end
          satq_pkg::OP_DELETE: begin
            cmd.tbl_op = satq_pkg::DP_REM_ID;
          end
          default: ;
        endcase
      end
      S_PLACE: begin
        cmd.tbl_op = satq_pkg::DP_PLACE;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.res_kind = res_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      res_r       <= satq_pkg::RES_OK;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: verif/sorted_alarm_timer_queue_top_tb.sv
// Self-checking testbench for the sorted alarm timer queue: directed and random alarm traffic.
`timescale 1ns / 100ps

module sorted_alarm_timer_queue_top_tb;
  import satq_pkg::*;

  localparam int IDLE_LIMIT      = 5000;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 317;
  localparam int DRAIN_CYCLES    = 12;
  localparam int PRINT_LIMIT     = 100;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [PER_W-1:0]  PER_MAX  = '1;

  // op mix per random phase, in percent; the rest are deletes
  localparam int INSERT_PCT [NUM_PHASES] = '{50, 75, 30, 60, 40, 70};
  localparam int CHECK_PCT  [NUM_PHASES] = '{35, 20, 60, 25, 45, 25};

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_WAVE} stall_mode_t;

  // Alarm table predictor plus the queue of results still owed by the block
  class alarm_scoreboard;
    logic [ID_W-1:0]   alarm_ids   [QUEUE_DEPTH];
    logic [TIME_W-1:0] deadlines   [QUEUE_DEPTH];
    logic [PER_W-1:0]  periods     [QUEUE_DEPTH];
    int                used;
    out_item_t         owed_q [$];
    int unsigned       errors;
    int unsigned       results_seen;

    function new();
      used = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    static function logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    function int find_id(logic [ID_W-1:0] id);
      for (int i = 0; i < used; i++) begin
        if (alarm_ids[i] == id) return i;
      end
      return -1;
    endfunction

    // close the gap left by a removed entry
    function void drop_at(int pos);
      for (int i = pos; i + 1 < used; i++) begin
        alarm_ids[i] = alarm_ids[i + 1];
        deadlines[i] = deadlines[i + 1];
        periods[i]   = periods[i + 1];
      end
      used--;
    endfunction

    // new entry goes after every entry with deadline <= t
    function void place_sorted(logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                               logic [PER_W-1:0] p);
      int pos;
      if (used >= QUEUE_DEPTH) return;
      pos = 0;
      while (pos < used && deadlines[pos] <= t) pos++;
      for (int i = used; i > pos; i--) begin
        alarm_ids[i] = alarm_ids[i - 1];
        deadlines[i] = deadlines[i - 1];
        periods[i]   = periods[i - 1];
      end
      alarm_ids[pos] = id;
      deadlines[pos] = t;
      periods[pos]   = p;
      used++;
    endfunction

    function void note_item(in_item_t it);
      out_item_t         r;
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] head_dl;
      logic [PER_W-1:0]  head_per;
      logic [ID_W-1:0]   head_id;
      bit                ok;
      int                k;
      r = '0;
      case (it.opcode)
        OP_CHECK: begin
          if (used > 0) begin
            if (it.current_time < deadlines[0]) begin
              r.head_pending = 1'b1;
              r.wait_seconds = deadlines[0] - it.current_time;
            end else begin
              head_id  = alarm_ids[0];
              head_dl  = deadlines[0];
              head_per = periods[0];
              drop_at(0);
              r.fired    = 1'b1;
              r.fired_id = head_id;
              if (head_per != '0)
                place_sorted(head_id, add_sat(head_dl, TIME_W'(head_per)), head_per);
            end
          end
        end
        OP_INSERT: begin
          t  = it.target_time;
          ok = 1'b1;
          // past date: try the same time tomorrow
          if (it.from_date && t < it.current_time) begin
            t = add_sat(t, TIME_W'(DAY_SECONDS));
            if (t < it.current_time) begin
              r.status = ST_OLD;
              ok = 1'b0;
            end
          end
          if (ok) begin
            k = find_id(it.alarm_id);
            if (k < 0 && used >= QUEUE_DEPTH) begin
              r.status = ST_FULL;
            end else begin
              if (k >= 0) drop_at(k);
              place_sorted(it.alarm_id, t, it.repeat_period);
            end
          end
        end
        OP_DELETE: begin
          k = find_id(it.alarm_id);
          if (k >= 0) drop_at(k);
        end
        default: ;
      endcase
      owed_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item outstanding", results_seen));
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                  results_seen, got.status, want.status));
      if (got.fired !== want.fired)
        report_mismatch($sformatf("result %0d fired %0b, want %0b",
                                  results_seen, got.fired, want.fired));
      if (got.fired_id !== want.fired_id)
        report_mismatch($sformatf("result %0d fired_id %0d, want %0d",
                                  results_seen, got.fired_id, want.fired_id));
      if (got.head_pending !== want.head_pending)
        report_mismatch($sformatf("result %0d head_pending %0b, want %0b",
                                  results_seen, got.head_pending, want.head_pending));
      if (got.wait_seconds !== want.wait_seconds)
        report_mismatch($sformatf("result %0d wait_seconds %0h, want %0h",
                                  results_seen, got.wait_seconds, want.wait_seconds));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  alarm_scoreboard   sb = new();
  logic [TIME_W-1:0] now_t = '0;
  int unsigned       idle_cycles = 0;

  sorted_alarm_timer_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: segments of random length, each with its own stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int          seg_left = 0;
  int          wave_cnt = 0;
  int          wave_len = 1;

  always @(posedge clk) begin
    if (seg_left == 0) begin
      seg_left   = $urandom_range(20, 200);
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      wave_len   = $urandom_range(1, 6);
      wave_cnt   = 0;
    end else begin
      seg_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        wave_cnt++;
        if (wave_cnt >= wave_len) begin
          wave_cnt = 0;
          out_stall <= ~out_stall;
        end
      end
    endcase
  end

  // Both channel monitors and the no-progress watchdog
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_item(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Hold the item on the bus until the block takes it; valid stays high on return
  task automatic send_item(input in_item_t it);
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  function automatic in_item_t mk_item(logic [1:0] op, logic [ID_W-1:0] id,
                                       logic [TIME_W-1:0] target, logic [PER_W-1:0] per,
                                       logic fd, logic [TIME_W-1:0] now);
    in_item_t it;
    it.opcode        = op;
    it.alarm_id      = id;
    it.target_time   = target;
    it.repeat_period = per;
    it.from_date     = fd;
    it.current_time  = now;
    return it;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [7:0]  hi;
    logic [31:0] lo;
    hi = 8'($urandom_range(0, 255));
    lo = $urandom;
    return {hi, lo};
  endfunction

  function automatic logic [TIME_W-1:0] back_off(logic [TIME_W-1:0] t, int unsigned d);
    return (t > TIME_W'(d)) ? t - TIME_W'(d) : '0;
  endfunction

  // Random alarm traffic around a mostly advancing present time
  function automatic in_item_t random_item(int phase);
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) now_t = rand_time();
    else if (pick < 5) now_t = TIME_MAX - TIME_W'($urandom_range(0, 200));
    else now_t = alarm_scoreboard::add_sat(now_t, TIME_W'($urandom_range(0, 8)));

    pick = $urandom_range(0, 99);
    if (pick < INSERT_PCT[phase]) it.opcode = OP_INSERT;
    else if (pick < INSERT_PCT[phase] + CHECK_PCT[phase]) it.opcode = OP_CHECK;
    else it.opcode = OP_DELETE;

    // small id pool so the table fills and ids collide
    it.alarm_id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, 255))
                                              : ID_W'($urandom_range(0, 19));

    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        it.target_time = alarm_scoreboard::add_sat(now_t, TIME_W'($urandom_range(0, 60)));
      6:       it.target_time = back_off(now_t, $urandom_range(0, 100));
      7:       it.target_time = back_off(now_t, $urandom_range(86300, 86500));
      8:       it.target_time = rand_time();
      default: it.target_time = TIME_MAX - TIME_W'($urandom_range(0, 100));
    endcase

    case ($urandom_range(0, 9))
      0, 1, 2, 3: it.repeat_period = '0;
      4, 5, 6, 7: it.repeat_period = $urandom_range(1, 50);
      8:          it.repeat_period = $urandom;
      default:    it.repeat_period = PER_MAX;
    endcase

    it.from_date    = 1'($urandom_range(0, 1));
    it.current_time = now_t;
    return it;
  endfunction

  initial begin
    in_item_t it;
    int       burst_left;
    int       gap;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, date adjustment, ties, repeats, saturation
    send_item(mk_item(OP_CHECK,  8'd0,   '0,             '0,      1'b0, '0));
    send_item(mk_item(OP_DELETE, 8'd5,   '0,             '0,      1'b0, '0));
    send_item(mk_item(OP_INSERT, 8'd0,   '0,             '0,      1'b0, '0));
    send_item(mk_item(OP_INSERT, 8'd255, TIME_MAX,       PER_MAX, 1'b0, '0));
    send_item(mk_item(OP_INSERT, 8'd10,  40'd100,        32'd50,  1'b1, 40'd50));
    send_item(mk_item(OP_INSERT, 8'd30,  40'd100,        '0,      1'b0, 40'd50));
    // still past after a day: rejected, id 10 keeps its entry
    send_item(mk_item(OP_INSERT, 8'd10,  '0,             32'd50,  1'b1, 40'd200000));
    // past but rescued by the next-day bump
    send_item(mk_item(OP_INSERT, 8'd20,  40'd1000,       32'd7,   1'b1, 40'd2000));
    // next-day bump saturates at the top of the time range
    send_item(mk_item(OP_INSERT, 8'd40,  TIME_MAX - 40'd10, 32'd3, 1'b1, TIME_MAX));
    send_item(mk_item(OP_DELETE, 8'd20,  '0,             '0,      1'b0, '0));
    send_item(mk_item(OP_CHECK,  8'd0,   '0,             '0,      1'b0, '0));
    send_item(mk_item(OP_CHECK,  8'd0,   '0,             '0,      1'b0, 40'd60));
    send_item(mk_item(OP_CHECK,  8'd0,   '0,             '0,      1'b0, 40'd100));
    send_item(mk_item(OP_CHECK,  8'd0,   '0,             '0,      1'b0, 40'd100));
    send_item(mk_item(OP_CHECK,  8'd0,   '0,             '0,      1'b0, 40'd120));
    send_item(mk_item(OP_CHECK,  8'd0,   '0,             '0,      1'b0, TIME_MAX));
    send_item(mk_item(OP_DELETE, 8'd10,  '0,             '0,      1'b0, '0));
    // repeating alarms whose next deadline overflows
    send_item(mk_item(OP_CHECK,  8'd0,   '0,             '0,      1'b0, TIME_MAX));
    send_item(mk_item(OP_CHECK,  8'd0,   '0,             '0,      1'b0, TIME_MAX));
    send_item(mk_item(OP_DELETE, 8'd255, '0,             '0,      1'b0, '0));
    send_item(mk_item(OP_DELETE, 8'd40,  '0,             '0,      1'b0, '0));
    send_item(mk_item(OP_CHECK,  8'd0,   '0,             '0,      1'b0, TIME_MAX));
    drain_results();

    // Random phases: sender bursts and gaps, full drain between phases
    now_t = rand_time();
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it = random_item(phase);
        send_item(it);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
          gap = $urandom_range(0, 8);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sorted_alarm_timer_queue_top.f
design/satq_pkg.sv
design/satq_datapath.sv
design/satq_ctrl.sv
design/sorted_alarm_timer_queue_top.sv
verif/sorted_alarm_timer_queue_top_tb.sv
